>>> hdl/dq_pkg.sv
`timescale 1ns / 1ps
package dq_pkg;

	// storage geometry
	localparam int DEPTH = 16;
	localparam int ELEM_W = 32;

	// fixed field widths
	localparam int REQ_W = 4;
	localparam int DATA_W = 32;
	localparam int POS_W = 4;
	localparam int PWDATA_W = 32;
	localparam int PADDR_W = 3;

	// derived widths
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int NUM_W = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;
	localparam int STEP_W = $clog2(NUM_W + 1);

	// register index (word address)
	localparam logic [PADDR_W-3:0] REG_CAP = '0;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_HEAD = 4'd0,
		REQ_PUSH_TAIL = 4'd1,
		REQ_POP_HEAD  = 4'd2,
		REQ_POP_TAIL  = 4'd3,
		REQ_DROP_HEAD = 4'd4,
		REQ_DROP_TAIL = 4'd5,
		REQ_READ_AT   = 4'd6,
		REQ_READ_HEAD = 4'd7,
		REQ_READ_TAIL = 4'd8,
		REQ_CLEAR     = 4'd9
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_MOD,
		ST_MEM,
		ST_DATA,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic mod_start;
		logic commit;
		logic capture;
	} cmd_t;

	typedef struct packed {
		logic mod_done;
	} status_t;

endpackage

>>> hdl/dq_ram.sv
`timescale 1ns / 1ps
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                          wdata,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/dq_mod.sv
`timescale 1ns / 1ps
// Restoring remainder, one numerator bit per cycle.
module dq_mod (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [dq_pkg::NUM_W-1:0] num,
	input  logic [dq_pkg::CNT_W-1:0] den,
	output logic                     busy,
	output logic [dq_pkg::CNT_W-1:0] rem
);

	logic                      busy_q;
	logic [dq_pkg::STEP_W-1:0] step_q;
	logic [dq_pkg::NUM_W-1:0]  num_q;
	logic [dq_pkg::CNT_W-1:0]  den_q;
	logic [dq_pkg::CNT_W-1:0]  rem_q;
	logic [dq_pkg::CNT_W:0]    trial;
	logic [dq_pkg::CNT_W:0]    diff;

	assign trial = {rem_q, num_q[dq_pkg::NUM_W-1]};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= dq_pkg::STEP_W'(dq_pkg::NUM_W);
		end else if (busy_q) begin
			step_q <= step_q - dq_pkg::STEP_W'(1);
			if (step_q == dq_pkg::STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[dq_pkg::NUM_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= diff[dq_pkg::CNT_W-1:0];
			end else begin
				rem_q <= trial[dq_pkg::CNT_W-1:0];
			end
		end
	end

	assign busy = busy_q;
	assign rem = rem_q;

endmodule

>>> hdl/dq_ctrl.sv
`timescale 1ns / 1ps
module dq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	input  dq_pkg::status_t  status,
	output dq_pkg::cmd_t     cmd
);

	dq_pkg::state_t state_q;
	dq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dq_pkg::ST_IDLE: begin
				if (req_valid) state_d = dq_pkg::ST_START;
			end
			dq_pkg::ST_START: state_d = dq_pkg::ST_MOD;
			dq_pkg::ST_MOD: begin
				if (status.mod_done) state_d = dq_pkg::ST_MEM;
			end
			dq_pkg::ST_MEM: state_d = dq_pkg::ST_DATA;
			dq_pkg::ST_DATA: state_d = dq_pkg::ST_RESP;
			dq_pkg::ST_RESP: begin
				if (rsp_ready) state_d = dq_pkg::ST_IDLE;
			end
			default: state_d = dq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		unique case (state_q)
			dq_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load = req_valid;
			end
			dq_pkg::ST_START: cmd.mod_start = 1'b1;
			dq_pkg::ST_MOD: ;
			dq_pkg::ST_MEM: cmd.commit = 1'b1;
			dq_pkg::ST_DATA: cmd.capture = 1'b1;
			dq_pkg::ST_RESP: rsp_valid = 1'b1;
			default: ;
		endcase
	end

endmodule

>>> hdl/dq_dp.sv
`timescale 1ns / 1ps
module dq_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dq_pkg::cmd_t                 cmd,
	output dq_pkg::status_t              status,
	input  logic [dq_pkg::REQ_W-1:0]     req_type,
	input  logic [dq_pkg::DATA_W-1:0]    item_in,
	input  logic [dq_pkg::POS_W-1:0]     position,
	output logic                         ok,
	output logic [dq_pkg::DATA_W-1:0]    item_out,
	output logic [dq_pkg::CNT_W-1:0]     fill_count,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dq_pkg::PADDR_W-1:0]   paddr,
	input  logic [dq_pkg::PWDATA_W-1:0]  pwdata,
	output logic [dq_pkg::PWDATA_W-1:0]  prdata
);

	logic [dq_pkg::REQ_W-1:0]  req_q;
	logic [dq_pkg::ELEM_W-1:0] item_q;
	logic [dq_pkg::POS_W-1:0]  pos_q;
	logic [dq_pkg::CNT_W-1:0]  cap_q;
	logic [dq_pkg::CNT_W-1:0]  cap_eff;
	logic [dq_pkg::IDX_W-1:0]  head_q, tail_q;
	logic [dq_pkg::CNT_W-1:0]  count_q;
	logic [dq_pkg::IDX_W-1:0]  head_d, tail_d;
	logic [dq_pkg::CNT_W-1:0]  count_d;
	logic                      ok_now, rd_now;
	logic                      ok_keep_q, rd_keep_q;
	logic [dq_pkg::NUM_W-1:0]  num;
	logic                      mod_busy;
	logic [dq_pkg::CNT_W-1:0]  mod_rem;
	logic [dq_pkg::IDX_W-1:0]  rem_idx;
	logic                      ram_we;
	logic [dq_pkg::IDX_W-1:0]  ram_addr;
	logic [dq_pkg::ELEM_W-1:0] ram_rdata;
	logic                      ok_q;
	logic [dq_pkg::DATA_W-1:0] item_out_q;
	logic [dq_pkg::CNT_W-1:0]  fill_q;
	logic                      cap_sel;
	logic                      can_take;
	logic [dq_pkg::NUM_W-1:0]  head_w, tail_w, cap_w;

	// configuration
	assign cap_sel = (paddr[dq_pkg::PADDR_W-1:2] == dq_pkg::REG_CAP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= dq_pkg::CNT_W'(dq_pkg::DEPTH);
		end else if (psel && penable && pwrite && cap_sel) begin
			cap_q <= pwdata[dq_pkg::CNT_W-1:0];
		end
	end

	assign prdata = cap_sel ? dq_pkg::PWDATA_W'(cap_q) : '0;

	// zero acts as one, oversize acts as full storage
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = dq_pkg::CNT_W'(1);
		end else if (cap_q > dq_pkg::CNT_W'(dq_pkg::DEPTH)) begin
			cap_eff = dq_pkg::CNT_W'(dq_pkg::DEPTH);
		end else begin
			cap_eff = cap_q;
		end
	end

	// request word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			item_q <= item_in[dq_pkg::ELEM_W-1:0];
			pos_q <= position;
		end
	end

	assign head_w = dq_pkg::NUM_W'(head_q);
	assign tail_w = dq_pkg::NUM_W'(tail_q);
	assign cap_w = dq_pkg::NUM_W'(cap_eff);
	assign can_take = (count_q != '0) && (count_q <= cap_eff);

	// success check and ring-step numerator
	always_comb begin
		ok_now = 1'b0;
		rd_now = 1'b0;
		num = '0;
		unique case (req_q)
			dq_pkg::REQ_PUSH_HEAD: begin
				ok_now = count_q < cap_eff;
				num = head_w + cap_w - dq_pkg::NUM_W'(1);
			end
			dq_pkg::REQ_PUSH_TAIL: begin
				ok_now = count_q < cap_eff;
				num = tail_w + dq_pkg::NUM_W'(1);
			end
			dq_pkg::REQ_POP_HEAD, dq_pkg::REQ_READ_HEAD: begin
				ok_now = can_take;
				rd_now = 1'b1;
				num = head_w + dq_pkg::NUM_W'(1);
			end
			dq_pkg::REQ_DROP_HEAD: begin
				ok_now = can_take;
				num = head_w + dq_pkg::NUM_W'(1);
			end
			dq_pkg::REQ_POP_TAIL, dq_pkg::REQ_READ_TAIL: begin
				ok_now = can_take;
				rd_now = 1'b1;
				num = tail_w + cap_w - dq_pkg::NUM_W'(1);
			end
			dq_pkg::REQ_DROP_TAIL: begin
				ok_now = can_take;
				num = tail_w + cap_w - dq_pkg::NUM_W'(1);
			end
			dq_pkg::REQ_READ_AT: begin
				ok_now = dq_pkg::NUM_W'(pos_q) < dq_pkg::NUM_W'(count_q);
				rd_now = 1'b1;
				num = head_w + dq_pkg::NUM_W'(pos_q);
			end
			dq_pkg::REQ_CLEAR: ok_now = 1'b1;
			default: ;
		endcase
	end

	dq_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mod_start),
		.num    (num),
		.den    (cap_eff),
		.busy   (mod_busy),
		.rem    (mod_rem)
	);

	assign status.mod_done = !mod_busy;
	assign rem_idx = mod_rem[dq_pkg::IDX_W-1:0];

	// pointer update and store access
	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		count_d = count_q;
		ram_we = 1'b0;
		ram_addr = head_q;
		unique case (req_q)
			dq_pkg::REQ_PUSH_HEAD: begin
				ram_addr = rem_idx;
				ram_we = ok_now;
				head_d = rem_idx;
				count_d = count_q + dq_pkg::CNT_W'(1);
			end
			dq_pkg::REQ_PUSH_TAIL: begin
				ram_addr = tail_q;
				ram_we = ok_now;
				tail_d = rem_idx;
				count_d = count_q + dq_pkg::CNT_W'(1);
			end
			dq_pkg::REQ_POP_HEAD, dq_pkg::REQ_DROP_HEAD: begin
				head_d = rem_idx;
				count_d = count_q - dq_pkg::CNT_W'(1);
			end
			dq_pkg::REQ_POP_TAIL, dq_pkg::REQ_DROP_TAIL: begin
				ram_addr = rem_idx;
				tail_d = rem_idx;
				count_d = count_q - dq_pkg::CNT_W'(1);
			end
			dq_pkg::REQ_READ_TAIL, dq_pkg::REQ_READ_AT: ram_addr = rem_idx;
			dq_pkg::REQ_CLEAR: begin
				head_d = '0;
				tail_d = '0;
				count_d = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else if (cmd.commit && ok_now) begin
			head_q <= head_d;
			tail_q <= tail_d;
			count_q <= count_d;
		end
	end

	dq_ram #(
		.WIDTH (dq_pkg::ELEM_W),
		.DEPTH (dq_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.commit && ram_we),
		.addr  (ram_addr),
		.wdata (item_q),
		.rdata (ram_rdata)
	);

	// ok is taken before the commit changes the count
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			ok_keep_q <= ok_now;
			rd_keep_q <= rd_now;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ok_q <= ok_keep_q;
			item_out_q <= (ok_keep_q && rd_keep_q) ? dq_pkg::DATA_W'(ram_rdata) : '0;
			fill_q <= count_q;
		end
	end

	assign ok = ok_q;
	assign item_out = item_out_q;
	assign fill_count = fill_q;

endmodule

>>> hdl/ring_buffer_deque.sv
`timescale 1ns / 1ps
// Double-ended queue on a ring of DEPTH entries.
// Request channel (req_valid/req_ready): req_type, item_in, position.
// Response channel (rsp_valid/rsp_ready): ok, item_out, fill_count; one
// response word per request, in order.
// Capacity in use sits at byte address 0 of the APB port; clear the queue
// after changing it. pready is tied high.
// One request is handled at a time. Each request runs one ring-index
// remainder (next/previous pointer, or head plus position, modulo capacity)
// on a serial unit that takes one numerator bit per cycle. After the request
// word is accepted the controller steps through START, MOD, MEM and DATA
// before the response is valid in RESP; req_ready returns the cycle after
// the response is taken.
// While the receiver stalls the response word holds and req_ready stays low.
// Reset empties the queue (head, tail and count at zero), sets capacity to
// DEPTH and leaves the entry store as it was; entries never written read
// as unknown data.
module ring_buffer_deque (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic [dq_pkg::REQ_W-1:0]     req_type,
	input  logic [dq_pkg::DATA_W-1:0]    item_in,
	input  logic [dq_pkg::POS_W-1:0]     position,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output logic                         ok,
	output logic [dq_pkg::DATA_W-1:0]    item_out,
	output logic [dq_pkg::CNT_W-1:0]     fill_count,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dq_pkg::PADDR_W-1:0]   paddr,
	input  logic [dq_pkg::PWDATA_W-1:0]  pwdata,
	output logic [dq_pkg::PWDATA_W-1:0]  prdata,
	output logic                         pready
);

	dq_pkg::cmd_t    cmd;
	dq_pkg::status_t status;

	assign pready = 1'b1;

	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.status    (status),
		.cmd       (cmd)
	);

	dq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.req_type   (req_type),
		.item_in    (item_in),
		.position   (position),
		.ok         (ok),
		.item_out   (item_out),
		.fill_count (fill_count),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata)
	);

endmodule

>>> hdl/dq_checker.sv
`timescale 1ns / 1ps
module dq_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic                      ok,
	input logic [dq_pkg::DATA_W-1:0] item_out,
	input logic [dq_pkg::CNT_W-1:0]  fill_count
);

	// stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(ok) && $stable(item_out)
			&& $stable(fill_count))
		else $error("response word changed while stalled");

	// a failed request returns no data
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !ok |-> item_out == '0)
		else $error("failed request returned data");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> fill_count <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
		else $error("fill count above storage depth");

	// one request in flight at a time
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready && !rsp_valid)
		else $error("new request taken while one is in flight");

endmodule

bind ring_buffer_deque dq_checker u_dq_checker (.*);
